// ===== src/bmsr_pkg.sv =====
`default_nettype none

package bmsr_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int IN_W  = 16;
    localparam int TS_W  = 32;
    localparam int CFG_W = 11;
    localparam int OUT_W = 16;

    localparam int X_W     = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int COUNT_W = $clog2(MAX_SAMPLES);
    localparam int N_W     = COUNT_W + 1;
    localparam int VSUM_W  = X_W + COUNT_W;
    localparam int SSUM_W  = 2 * X_W + COUNT_W;
    localparam int TSUM_W  = TS_W + COUNT_W;

    localparam int SS_LO_W = SSUM_W / 2;
    localparam int SS_HI_W = SSUM_W - SS_LO_W;
    localparam int PLO_W   = SS_LO_W + N_W;
    localparam int PHI_W   = SS_HI_W + N_W;
    localparam int PROD_W  = N_W + SSUM_W;
    localparam int VSQ_W   = 2 * VSUM_W;
    localparam int NUM_W   = PROD_W;
    localparam int DIV_W   = NUM_W + 2;
    localparam int DEN_W   = 2 * N_W;
    localparam int MD_W    = VSUM_W + 2;
    localparam int ROOT_W  = (DIV_W + 1) / 2;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int STEP_W  = $clog2(DIV_W + 1);
    localparam int RCNT_W  = $clog2(ROOT_W + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLES_PER_REPORT = REG_IDX_W'(0);
    localparam logic [CFG_W-1:0]     CFG_RESET              = CFG_W'(6);

    typedef struct packed {
        logic [TSUM_W-1:0] time_sum;
        logic [VSUM_W-1:0] value_sum;
        logic [SSUM_W-1:0] square_sum;
        logic [N_W-1:0]    n;
    } block_rec_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_ACCUM
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_TDIV_GO,
        B_TDIV_WAIT,
        B_MDIV_GO,
        B_MDIV_WAIT,
        B_MUL,
        B_SUM,
        B_SUB,
        B_RDIV_GO,
        B_RDIV_WAIT,
        B_SQRT,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/bmsr_front.sv =====
`default_nettype none

module bmsr_front
    import bmsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [IN_W-1:0]  sample_value,
    input  logic [TS_W-1:0]  timestamp_seconds,
    input  logic [CFG_W-1:0] samples_per_report,
    input  logic             fifo_full,
    output logic             push,
    output block_rec_t       push_rec
);

    front_state_t        state_reg;
    front_state_t        state_next;
    logic                first_pending_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [VSUM_W-1:0]   vsum_reg;
    logic [SSUM_W-1:0]   ssum_reg;
    logic [TSUM_W-1:0]   tsum_reg;
    logic [X_W-1:0]      x_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [2*X_W-1:0]    sq_reg;

    logic [N_W-1:0]      n;
    logic [N_W-1:0]      count_inc;
    logic [VSUM_W-1:0]   vsum_new;
    logic [SSUM_W-1:0]   ssum_new;
    logic [TSUM_W-1:0]   tsum_new;
    logic                report;
    logic                take;

    always_comb
    begin
        if (samples_per_report == '0)
        begin
            n = N_W'(1);
        end
        else if (32'(samples_per_report) > 32'(MAX_SAMPLES))
        begin
            n = N_W'(MAX_SAMPLES);
        end
        else
        begin
            n = N_W'(samples_per_report);
        end
    end

    assign count_inc = {1'b0, count_reg} + N_W'(1);
    assign vsum_new  = vsum_reg + VSUM_W'(x_reg);
    assign ssum_new  = ssum_reg + SSUM_W'(sq_reg);
    assign tsum_new  = tsum_reg + TSUM_W'(ts_reg);
    assign report    = (count_inc >= n);
    assign take      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && !first_pending_reg)
                begin
                    state_next = F_SQUARE;
                end
            end
            F_SQUARE:
            begin
                state_next = F_ACCUM;
            end
            F_ACCUM:
            begin
                if (!report || !fifo_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
            end
            F_ACCUM:
            begin
                push = report && !fifo_full;
            end
            default:
            begin
                in_ready = 1'b0;
                push     = 1'b0;
            end
        endcase
    end

    assign push_rec.time_sum   = tsum_new;
    assign push_rec.value_sum  = vsum_new;
    assign push_rec.square_sum = ssum_new;
    assign push_rec.n          = n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= F_IDLE;
            first_pending_reg <= 1'b1;
            count_reg         <= '0;
            vsum_reg          <= '0;
            ssum_reg          <= '0;
            tsum_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (take && first_pending_reg)
            begin
                first_pending_reg <= 1'b0;
            end
            if (state_reg == F_ACCUM)
            begin
                if (!report)
                begin
                    count_reg <= count_inc[COUNT_W-1:0];
                    vsum_reg  <= vsum_new;
                    ssum_reg  <= ssum_new;
                    tsum_reg  <= tsum_new;
                end
                else if (push)
                begin
                    count_reg <= '0;
                    vsum_reg  <= '0;
                    ssum_reg  <= '0;
                    tsum_reg  <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg  <= sample_value[X_W-1:0];
            ts_reg <= timestamp_seconds;
        end
        if (state_reg == F_SQUARE)
        begin
            sq_reg <= x_reg * x_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/bmsr_fifo.sv =====
`default_nettype none

module bmsr_fifo
    import bmsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  block_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output block_rec_t pop_rec,
    output logic       empty
);

    block_rec_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   cnt_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic                    do_push;
    logic                    do_pop;

    assign full    = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

// ===== src/bmsr_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. Dividend comes left-aligned;
// once ctl.steps quotient bits have been shifted in, the quotient sits in the low bits.
module bmsr_div
    import bmsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   dvs_reg;
    logic [DIV_W-1:0]   quo_reg;

    logic [DEN_W:0]     trial;
    logic               ge;
    logic [DEN_W-1:0]   rem_next;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_next = ge ? DEN_W'(trial - {1'b0, dvs_reg}) : DEN_W'(trial);

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== src/bmsr_back.sv =====
`default_nettype none

module bmsr_back
    import bmsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fifo_empty,
    input  block_rec_t        pop_rec,
    output logic              pop,
    output div_ctl_t          div_ctl,
    output logic [DIV_W-1:0]  div_dividend,
    output logic [DEN_W-1:0]  div_divisor,
    input  logic              div_done,
    input  logic [DIV_W-1:0]  div_quotient,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [TS_W-1:0]   mean_time,
    output logic [OUT_W-1:0]  sample_mean,
    output logic [OUT_W-1:0]  sample_stddev
);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [RCNT_W-1:0]    rcnt_reg;
    logic                 out_valid_reg;

    block_rec_t           rec_reg;
    logic [TS_W-1:0]      mt_reg;
    logic [OUT_W-1:0]     lm_reg;
    logic [PLO_W-1:0]     plo_reg;
    logic [PHI_W-1:0]     phi_reg;
    logic [VSQ_W-1:0]     vsq_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [SQ_W-1:0]      sq_in_reg;
    logic [ROOT_W:0]      rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [TS_W-1:0]      out_mt_reg;
    logic [OUT_W-1:0]     out_lm_reg;
    logic [OUT_W-1:0]     out_sd_reg;

    logic                 n_is_one;
    logic [MD_W-1:0]      mean_dividend;
    logic [N_W-1:0]       n_minus_one;
    logic [ROOT_W+2:0]    sq_cur;
    logic [ROOT_W+2:0]    sq_trial;
    logic                 sq_ge;
    logic [ROOT_W:0]      root_inc;
    logic [ROOT_W-1:0]    k_val;
    logic [OUT_W-1:0]     sd_val;
    logic [OUT_W-1:0]     lm_val;
    logic                 out_load;

    assign n_is_one      = (rec_reg.n == N_W'(1));
    assign mean_dividend = MD_W'({rec_reg.value_sum, 1'b0}) + MD_W'(rec_reg.n);
    assign n_minus_one   = rec_reg.n - N_W'(1);

    assign sq_cur   = {rem_reg, sq_in_reg[SQ_W-1 -: 2]};
    assign sq_trial = (ROOT_W+3)'({root_reg, 2'b01});
    assign sq_ge    = (sq_cur >= sq_trial);

    // stddev = floor((isqrt(floor(4*num/den)) + 1) / 2), saturated; 0 when n is 1
    assign root_inc = {1'b0, root_reg} + (ROOT_W+1)'(1);
    assign k_val    = root_inc[ROOT_W:1];
    assign sd_val   = n_is_one ? '0
                               : ((|k_val[ROOT_W-1:OUT_W]) ? '1 : k_val[OUT_W-1:0]);
    assign lm_val   = (|div_quotient[DIV_W-1:OUT_W]) ? '1 : div_quotient[OUT_W-1:0];

    assign out_load = (state_reg == B_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    state_next = B_TDIV_GO;
                end
            end
            B_TDIV_GO:
            begin
                state_next = B_TDIV_WAIT;
            end
            B_TDIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = B_MDIV_GO;
                end
            end
            B_MDIV_GO:
            begin
                state_next = B_MDIV_WAIT;
            end
            B_MDIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = n_is_one ? B_DONE : B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_SUM;
            end
            B_SUM:
            begin
                state_next = B_SUB;
            end
            B_SUB:
            begin
                state_next = B_RDIV_GO;
            end
            B_RDIV_GO:
            begin
                state_next = B_RDIV_WAIT;
            end
            B_RDIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (rcnt_reg == RCNT_W'(1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop           = 1'b0;
        div_ctl.start = 1'b0;
        div_ctl.steps = '0;
        div_dividend  = '0;
        div_divisor   = '0;
        case (state_reg)
            B_IDLE:
            begin
                pop = !fifo_empty;
            end
            B_TDIV_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(TSUM_W);
                div_dividend  = DIV_W'(rec_reg.time_sum) << (DIV_W - TSUM_W);
                div_divisor   = DEN_W'(rec_reg.n);
            end
            B_MDIV_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(MD_W);
                div_dividend  = DIV_W'(mean_dividend) << (DIV_W - MD_W);
                div_divisor   = DEN_W'({rec_reg.n, 1'b0});
            end
            B_RDIV_GO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = STEP_W'(DIV_W);
                div_dividend  = {num_reg, 2'b00};
                div_divisor   = den_reg;
            end
            default:
            begin
                pop           = 1'b0;
                div_ctl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_RDIV_WAIT && div_done)
            begin
                rcnt_reg <= RCNT_W'(ROOT_W);
            end
            else if (state_reg == B_SQRT)
            begin
                rcnt_reg <= rcnt_reg - 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= pop_rec;
        end
        if (state_reg == B_TDIV_WAIT && div_done)
        begin
            mt_reg <= div_quotient[TS_W-1:0];
        end
        if (state_reg == B_MDIV_WAIT && div_done)
        begin
            lm_reg <= lm_val;
        end
        if (state_reg == B_MUL)
        begin
            plo_reg <= PLO_W'(rec_reg.square_sum[SS_LO_W-1:0]) * PLO_W'(rec_reg.n);
            phi_reg <= PHI_W'(rec_reg.square_sum[SSUM_W-1:SS_LO_W]) * PHI_W'(rec_reg.n);
            vsq_reg <= VSQ_W'(rec_reg.value_sum) * VSQ_W'(rec_reg.value_sum);
            den_reg <= DEN_W'(rec_reg.n) * DEN_W'(n_minus_one);
        end
        if (state_reg == B_SUM)
        begin
            prod_reg <= (PROD_W'(phi_reg) << SS_LO_W) + PROD_W'(plo_reg);
        end
        if (state_reg == B_SUB)
        begin
            num_reg <= (prod_reg >= PROD_W'(vsq_reg)) ? NUM_W'(prod_reg - PROD_W'(vsq_reg))
                                                      : '0;
        end
        if (state_reg == B_RDIV_WAIT && div_done)
        begin
            sq_in_reg <= SQ_W'(div_quotient);
            rem_reg   <= '0;
            root_reg  <= '0;
        end
        else if (state_reg == B_SQRT)
        begin
            sq_in_reg <= sq_in_reg << 2;
            rem_reg   <= sq_ge ? (ROOT_W+1)'(sq_cur - sq_trial) : (ROOT_W+1)'(sq_cur);
            root_reg  <= {root_reg[ROOT_W-2:0], sq_ge};
        end
        if (out_load)
        begin
            out_mt_reg <= mt_reg;
            out_lm_reg <= lm_reg;
            out_sd_reg <= sd_val;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mean_time     = out_mt_reg;
    assign sample_mean   = out_lm_reg;
    assign sample_stddev = out_sd_reg;

endmodule

`default_nettype wire

// ===== src/block_mean_stddev_reporter.sv =====
// A block's last request is accumulated in the front and queued; the shared divider and
// the square-root loop in the back set the report latency (only the time and mean divisions
// run when the block length is 1). A new request is taken only after the last is accumulated
// and, if it ends a block, queued; two finished blocks can wait between front and back.
// Reset: rst_n asynchronous, active low; sums cleared, samples_per_report = 6,
// and the first request after reset is dropped.
`default_nettype none

module block_mean_stddev_reporter
    import bmsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [IN_W-1:0]    sample_value,
    input  logic [TS_W-1:0]    timestamp_seconds,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [TS_W-1:0]    mean_time,
    output logic [OUT_W-1:0]   sample_mean,
    output logic [OUT_W-1:0]   sample_stddev
);

    logic [CFG_W-1:0]     spr_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_wr;

    logic                 fifo_full;
    logic                 fifo_empty;
    logic                 push;
    logic                 pop;
    block_rec_t           push_rec;
    block_rec_t           pop_rec;

    div_ctl_t             div_ctl;
    logic [DIV_W-1:0]     div_dividend;
    logic [DEN_W-1:0]     div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quotient;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (reg_idx == REG_SAMPLES_PER_REPORT);
    assign prdata  = (reg_idx == REG_SAMPLES_PER_REPORT) ? PDATA_W'(spr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            spr_reg <= pwdata[CFG_W-1:0];
        end
    end

    bmsr_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample_value      (sample_value),
        .timestamp_seconds (timestamp_seconds),
        .samples_per_report(spr_reg),
        .fifo_full         (fifo_full),
        .push              (push),
        .push_rec          (push_rec)
    );

    bmsr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (fifo_full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (fifo_empty)
    );

    bmsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    bmsr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fifo_empty    (fifo_empty),
        .pop_rec       (pop_rec),
        .pop           (pop),
        .div_ctl       (div_ctl),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mean_time     (mean_time),
        .sample_mean   (sample_mean),
        .sample_stddev (sample_stddev)
    );

endmodule

`default_nettype wire

// ===== src/bmsr_checker.sv =====
`default_nettype none

module bmsr_checker
    import bmsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [TS_W-1:0]    mean_time,
    input  logic [OUT_W-1:0]   sample_mean,
    input  logic [OUT_W-1:0]   sample_stddev
);

    logic cfg_write;

    assign cfg_write = psel && penable && pwrite && pready;

    // stalled report holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(mean_time) && $stable(sample_mean)
             && $stable(sample_stddev)))
        else $error("report changed while stalled");

    a_no_report_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("report right after reset");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && paddr[PADDR_W-1:2] == '0) |=>
            ((paddr[PADDR_W-1:2] != '0)
             || (prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))))
        else $error("samples_per_report readback mismatch");

    a_cfg_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[PDATA_W-1:CFG_W] == '0)
        else $error("prdata upper bits not zero");

endmodule

bind block_mean_stddev_reporter bmsr_checker u_bmsr_checker (.*);

`default_nettype wire
